// ===== hdl/histogram_bucket_index_top_macros.svh =====
// Assertion macros shared by the histogram bucket index RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef HISTOGRAM_BUCKET_INDEX_TOP_MACROS_SVH
`define HISTOGRAM_BUCKET_INDEX_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HBI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hbi assertion failed");

// Next-cycle implication, disabled during reset
`define HBI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hbi assertion failed");

`endif

// ===== hdl/hbi_pkg.sv =====
// Shared types and constants for the histogram bucket index block.
// No dependencies.
package hbi_pkg;

  localparam int unsigned MaxBuckets = 64;

  // Item kinds
  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_BITS   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [5:0]         entry_slot;
    logic signed [63:0] lower_bound;
    logic signed [63:0] upper_bound;
    logic signed [63:0] sample;
  } in_t;

  typedef struct packed {
    logic [6:0]  bucket;
    logic [32:0] bit_index;
  } out_t;

  typedef struct packed {
    logic [6:0]  count;
    logic [15:0] bits;
    logic [31:0] offset;
  } cfg_t;

  // Queued command: a holds the low bound or the sample, b the high bound
  typedef struct packed {
    logic        is_load;
    logic [5:0]  slot;
    logic [63:0] a;
    logic [63:0] b;
  } cmd_t;

endpackage

// ===== hdl/histogram_bucket_index_top.sv =====
// Histogram bucket index: load items fill a table of up to MaxBuckets
// signed [low, high] buckets; classify items return the bucket of a sample
// and that bucket folded into index_bits positions plus index_offset. Items
// pass through a two-entry queue into a sequencer that owns a single-port
// table. A load is written to the table as it leaves the queue. A classify
// scans the buckets in order, one table read and compare per bucket, and
// stops at the first hit or after bucket_count buckets; when bucket_count
// exceeds index_bits, two bit-serial divisions follow. Configuration sits
// behind an APB-style port: bucket_count at 0x0, index_bits at 0x4,
// index_offset at 0x8.
// Depends on hbi_pkg, hbi_front, hbi_back.
module histogram_bucket_index_top #(
  parameter int unsigned MaxBuckets = hbi_pkg::MaxBuckets
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hbi_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hbi_pkg::out_t out_data_o
);

  hbi_pkg::cfg_t cfg_q;
  hbi_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready, wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count  <= 7'd0;
      cfg_q.bits   <= 16'd64;
      cfg_q.offset <= 32'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        hbi_pkg::REG_COUNT:  cfg_q.count  <= pwdata[6:0];
        hbi_pkg::REG_BITS:   cfg_q.bits   <= pwdata[15:0];
        hbi_pkg::REG_OFFSET: cfg_q.offset <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      hbi_pkg::REG_COUNT:  prdata = 32'(cfg_q.count);
      hbi_pkg::REG_BITS:   prdata = 32'(cfg_q.bits);
      hbi_pkg::REG_OFFSET: prdata = cfg_q.offset;
      default:             prdata = 32'd0;
    endcase
  end

  hbi_front #(
    .MaxBuckets (MaxBuckets)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  hbi_back #(
    .MaxBuckets (MaxBuckets)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/hbi_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module hbi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hbi_front.sv =====
// Front end: accepts input requests, drops loads to missing slots,
// and queues commands for the back end. Depends on hbi_pkg.
module hbi_front #(
  parameter int unsigned MaxBuckets = hbi_pkg::MaxBuckets
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hbi_pkg::in_t  in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output hbi_pkg::cmd_t cmd_o
);

  hbi_pkg::cmd_t ent_q [2];
  logic [1:0]    fill_q;
  logic          wptr_q, rptr_q;
  logic          push, pop, keep;
  hbi_pkg::cmd_t cmd_new;

  // Classify the request: loads beyond the table produce nothing
  always_comb begin
    cmd_new.is_load = (in_data_i.kind == hbi_pkg::KIND_LOAD);
    cmd_new.slot    = in_data_i.entry_slot;
    cmd_new.a       = cmd_new.is_load ? in_data_i.lower_bound : in_data_i.sample;
    cmd_new.b       = in_data_i.upper_bound;
    keep = !cmd_new.is_load || (32'(in_data_i.entry_slot) < MaxBuckets);
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = ent_q[rptr_q];

  // Two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= cmd_new;
    end
  end

  `include "histogram_bucket_index_top_macros.svh"

  `HBI_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= 2'd2)
  `HBI_ASSERT_IMPL(a_full_stalls, fill_q == 2'd2, !in_ready_o)
  `HBI_ASSERT_NEXT(a_push_shows, push && !pop && fill_q == 2'd0, cmd_valid_o)

endmodule

// ===== hdl/hbi_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// No dependencies.
module hbi_div #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, n_q, den_q, rem_d;
  logic [Width:0]   trial;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q, qbit;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, n_q[Width-1]} - {1'b0, den_q};
    qbit  = !trial[Width];
    rem_d = qbit ? trial[Width-1:0] : {rem_q[Width-2:0], n_q[Width-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(Width - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      n_q   <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      n_q   <= {n_q[Width-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

// ===== hdl/hbi_back.sv =====
// Back end: writes the bucket table, scans it for classify commands,
// folds the bucket number and registers the result. Depends on hbi_pkg,
// hbi_ram and hbi_div.
module hbi_back #(
  parameter int unsigned MaxBuckets = hbi_pkg::MaxBuckets
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hbi_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  hbi_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hbi_pkg::out_t out_data_o
);

  localparam int unsigned CW = $clog2(MaxBuckets + 1);
  localparam int unsigned AW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned DW = CW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SCL  = 3'd3;
  localparam logic [2:0] S_DIV1 = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] k_q, k_d, bucket_q, bucket_d, quot_q, quot_d, cnt;
  logic [63:0]   sample_q;
  logic [15:0]   bits;
  logic          fold, pop, out_load;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [127:0]  ram_rdata;
  logic [63:0]   lo, hi;
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den, div_quot;
  logic          out_valid_q;
  hbi_pkg::out_t out_q;

  // Effective count and fold width
  always_comb begin
    cnt  = (32'(cfg_i.count) > MaxBuckets) ? CW'(MaxBuckets) : CW'(cfg_i.count);
    bits = (cfg_i.bits == 16'd0) ? 16'd1 : cfg_i.bits;
    fold = (17'(cnt) > 17'(bits));
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign ram_we      = pop && cmd_i.is_load;
  assign ram_addr    = (state_q == S_IDLE) ? AW'(cmd_i.slot) : k_q[AW-1:0];
  assign lo          = ram_rdata[63:0];
  assign hi          = ram_rdata[127:64];
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  hbi_ram #(
    .Width (128),
    .Depth (MaxBuckets)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({cmd_i.b, cmd_i.a}),
    .rdata_o (ram_rdata)
  );

  // Divider operands: first the scale, then the bucket over the scale
  always_comb begin
    div_start = 1'b0;
    div_num   = DW'(bucket_q);
    div_den   = div_quot;
    if (state_q == S_SCL && fold) begin
      div_start = 1'b1;
      div_num   = DW'(cnt) + DW'(bits) - 1'b1;
      div_den   = DW'(bits);
    end else if (state_q == S_DIV1 && div_done) begin
      div_start = 1'b1;
    end
  end

  hbi_div #(
    .Width (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    bucket_d = bucket_q;
    quot_d   = quot_q;
    unique case (state_q)
      S_IDLE: begin
        k_d = '0;
        if (pop && !cmd_i.is_load) state_d = S_RD;
      end
      S_RD: begin
        if (k_q == cnt) begin
          bucket_d = cnt;
          state_d  = S_SCL;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if ($signed(sample_q) < $signed(lo)) begin
          bucket_d = (k_q == '0) ? '0 : k_q - 1'b1;
          state_d  = S_SCL;
        end else if (!($signed(hi) < $signed(sample_q))) begin
          bucket_d = k_q;
          state_d  = S_SCL;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_SCL: begin
        if (fold) begin
          state_d = S_DIV1;
        end else begin
          quot_d  = bucket_q;
          state_d = S_OUT;
        end
      end
      S_DIV1: begin
        if (div_done) state_d = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) begin
          quot_d  = CW'(div_quot);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bucket_q <= bucket_d;
    quot_q   <= quot_d;
    if (pop) sample_q <= cmd_i.a;
    if (out_load) begin
      out_q.bucket    <= 7'(bucket_q);
      out_q.bit_index <= 33'(quot_q) + {1'b0, cfg_i.offset};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "histogram_bucket_index_top_macros.svh"

  `HBI_ASSERT_IMPL(a_scan_bound, state_q == S_RD || state_q == S_CMP, k_q <= cnt)
  `HBI_ASSERT_IMPL(a_cmp_in_range, state_q == S_CMP, k_q < cnt)
  `HBI_ASSERT_IMPL(a_pop_idle, pop, state_q == S_IDLE)
  `HBI_ASSERT_NEXT(a_load_shows, out_load, out_valid_q && state_q == S_IDLE)

endmodule
